// File: hdl/hsc_pkg.sv
package hsc_pkg;

    localparam int NUM_W    = 48;
    localparam int DEN_W    = 32;
    localparam int QUO_W    = 16;
    localparam int DIV_LAT  = QUO_W + 1;

    localparam logic [16:0] Q15_ONE   = 17'd32768;
    localparam logic [14:0] MIN_SPAN  = 15'd10;
    localparam logic [31:0] MIN_BAND  = 32'd1677722;
    localparam logic signed [16:0] ERR_FULL_LIMIT = 17'sd12;

    localparam logic signed [15:0] CMD_MAX = 16'sh7fff;
    localparam logic signed [15:0] CMD_MIN = 16'sh8000;

    localparam logic [2:0] MODE_MOVING = 3'd0;
    localparam logic [2:0] MODE_ACCEL  = 3'd1;
    localparam logic [2:0] MODE_DECEL  = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;

    localparam logic [2:0] REG_TURN_SAT   = 3'd0;
    localparam logic [2:0] REG_SHARP_TURN = 3'd1;
    localparam logic [2:0] REG_MIN_FRAC   = 3'd2;
    localparam logic [2:0] REG_BAND_GAIN  = 3'd3;
    localparam logic [2:0] REG_TURN_THR   = 3'd4;
    localparam logic [2:0] REG_ATTACK     = 3'd5;

    localparam logic [1:0] ACC_DIV   = 2'd0;
    localparam logic [1:0] ACC_FULL  = 2'd1;
    localparam logic [1:0] ACC_BRAKE = 2'd2;

    typedef struct packed {
        logic signed [15:0] e;
        logic [15:0]        speed;
        logic [2:0]         mode;
        logic               gt;
    } t_side_a;

    typedef struct packed {
        logic [1:0] kind;
        logic       neg_a;
        logic       neg_t;
    } t_side_b;

    // signed command from a quotient magnitude, saturated to -1..1
    function automatic logic signed [15:0] sat_cmd(input logic neg, input logic ovf,
                                                   input logic [QUO_W-1:0] q);
        logic big;
        logic [16:0] negq;
        big  = ovf | q[15];
        negq = 17'd0 - {1'b0, q};
        if (neg) begin
            return big ? CMD_MIN : $signed(negq[15:0]);
        end
        return big ? CMD_MAX : $signed(q);
    endfunction

endpackage

// File: hdl/hsc_div.sv
module hsc_div
    import hsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_ovf
);

    logic [NUM_W-1:0] r_rem [DIV_LAT];
    logic [DEN_W-1:0] r_den [DIV_LAT];
    logic [QUO_W-1:0] r_quo [DIV_LAT];
    logic             r_ovf [DIV_LAT];

    // quotient too large for QUO_W bits: flag it and let the steps run freely
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (i_num >= {i_den, {QUO_W{1'b0}}});
        end
    end

    for (genvar s = 1; s < DIV_LAT; s++) begin : g_step
        localparam int K = QUO_W - s;
        logic [NUM_W-1:0] w_sh;
        logic             w_ge;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        always_comb begin
            w_sh  = NUM_W'(r_den[s-1]) << K;
            w_ge  = (r_rem[s-1] >= w_sh);
            n_rem = w_ge ? (r_rem[s-1] - w_sh) : r_rem[s-1];
            n_quo = r_quo[s-1];
            n_quo[K] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_den[s] <= r_den[s-1];
                r_quo[s] <= n_quo;
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];
    assign o_ovf = r_ovf[DIV_LAT-1];

endmodule

// File: hdl/heading_speed_command_top.sv
// Heading and speed command unit. Each transfer of desired heading, measured
// heading, speed and mode yields one transfer of turn and acceleration
// commands (Q1.15, saturated). The pipeline accepts one item every clock
// while the output is not stalled. It has two input stages, a 17-stage
// one-bit-per-stage divider for the slowdown fraction, four multiply/select
// stages, a second 17-stage divider pair for the turn and acceleration
// quotients, and the output register. The whole pipeline holds while a result
// waits at the output and the sink is not ready. The user must write registers
// through the plain write port only while the unit is idle; not enforced.
module heading_speed_command_top
    import hsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_desired_heading,
    input  logic [15:0]        i_heading,
    input  logic [15:0]        i_speed,
    input  logic [2:0]         i_mode,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_accel_cmd,
    output logic signed [15:0] o_turn_cmd
);

    logic [14:0] r_turn_sat, r_sharp_turn, r_turn_thr;
    logic [15:0] r_min_frac, r_band_gain, r_attack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_sat   <= 15'd8192;
            r_sharp_turn <= 15'd16384;
            r_min_frac   <= 16'd9830;
            r_band_gain  <= 16'd13107;
            r_turn_thr   <= 15'd2731;
            r_attack     <= 16'd5120;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TURN_SAT:   r_turn_sat   <= i_cfg_data[14:0];
                REG_SHARP_TURN: r_sharp_turn <= i_cfg_data[14:0];
                REG_MIN_FRAC:   r_min_frac   <= i_cfg_data;
                REG_BAND_GAIN:  r_band_gain  <= i_cfg_data;
                REG_TURN_THR:   r_turn_thr   <= i_cfg_data[14:0];
                REG_ATTACK:     r_attack     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective configuration
    logic [14:0]        w_sat;
    logic [15:0]        w_omf;
    logic signed [16:0] w_span_raw;
    logic [14:0]        w_span;

    always_comb begin
        w_sat      = (r_turn_sat == '0) ? 15'd1 : r_turn_sat;
        w_omf      = (r_min_frac > Q15_ONE[15:0]) ? 16'd0 : 16'(Q15_ONE - {1'b0, r_min_frac});
        w_span_raw = $signed({2'b00, r_sharp_turn}) - $signed({2'b00, r_turn_thr});
        w_span     = (w_span_raw < $signed({2'b00, MIN_SPAN})) ? MIN_SPAN : w_span_raw[14:0];
    end

    logic w_adv;
    logic r_o_valid;
    assign w_adv   = !r_o_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_o_valid;

    // stage 1: heading error
    logic               r1_v;
    logic signed [15:0] r1_e;
    logic [15:0]        r1_speed;
    logic [2:0]         r1_mode;

    // stage 2: slowdown division operands
    logic             r2_v;
    t_side_a          r2_side;
    logic [NUM_W-1:0] r2_num;
    logic [DEN_W-1:0] r2_den;
    logic [16:0]      w2_a;
    logic [16:0]      w2_excess;

    always_comb begin
        w2_a      = r1_e[15] ? 17'(-$signed({r1_e[15], r1_e})) : {1'b0, r1_e};
        w2_excess = w2_a - {2'b00, r_turn_thr};
    end

    // slowdown divider side line
    logic             r_tv [DIV_LAT];
    t_side_a          r_ta [DIV_LAT];
    logic [QUO_W-1:0] w_t_quo;
    logic             w_t_ovf;

    hsc_div u_div_frac (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r2_num),
        .i_den (r2_den),
        .o_quo (w_t_quo),
        .o_ovf (w_t_ovf)
    );

    // stages 3 to 6: fraction, target, error, final divider operands
    logic        r3_v, r4_v, r5_v, r6_v;
    t_side_a     r3_side, r4_side, r5_side;
    logic [31:0] r3_prod, r4_prod;
    logic signed [16:0] r5_err;
    logic [31:0] r5_band;
    logic [15:0] w3_t;
    logic [16:0] w4_frac;
    logic        w5_moving;
    logic [15:0] w5_target;

    always_comb begin
        if (!r_ta[DIV_LAT-1].gt) begin
            w3_t = '0;
        end else if (w_t_ovf || w_t_quo > Q15_ONE[15:0]) begin
            w3_t = Q15_ONE[15:0];
        end else begin
            w3_t = w_t_quo;
        end
        w4_frac   = Q15_ONE - r3_prod[31:15];
        w5_moving = (r4_side.mode == MODE_MOVING) || (r4_side.mode == MODE_ACCEL);
        if (w5_moving) begin
            w5_target = r4_prod[30:15];
        end else if (r4_side.mode == MODE_DECEL || r4_side.mode == MODE_STOP) begin
            w5_target = '0;
        end else begin
            w5_target = r4_side.speed;
        end
    end

    t_side_b          r6_side;
    logic [NUM_W-1:0] r6_num_a, r6_num_t;
    logic [DEN_W-1:0] r6_den_a, r6_den_t;
    logic             w6_moving;
    logic [16:0]      w6_err_mag;
    logic [16:0]      w6_e_mag;
    t_side_b          w6_side;

    always_comb begin
        w6_moving  = (r5_side.mode == MODE_MOVING) || (r5_side.mode == MODE_ACCEL);
        w6_err_mag = r5_err[16] ? 17'(-r5_err) : 17'(r5_err);
        w6_e_mag   = r5_side.e[15] ? 17'(-$signed({r5_side.e[15], r5_side.e}))
                                   : {1'b0, r5_side.e};
        w6_side.neg_a = r5_err[16];
        w6_side.neg_t = r5_side.e[15];
        if (w6_moving && r5_err > ERR_FULL_LIMIT) begin
            w6_side.kind = ACC_FULL;
        end else if (r5_side.mode == MODE_DECEL) begin
            w6_side.kind = ACC_BRAKE;
        end else begin
            w6_side.kind = ACC_DIV;
        end
    end

    // command dividers side line
    logic             r_bv [DIV_LAT];
    t_side_b          r_sb [DIV_LAT];
    logic [QUO_W-1:0] w_a_quo, w_turn_quo;
    logic             w_a_ovf, w_turn_ovf;

    hsc_div u_div_accel (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r6_num_a),
        .i_den (r6_den_a),
        .o_quo (w_a_quo),
        .o_ovf (w_a_ovf)
    );

    hsc_div u_div_turn (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r6_num_t),
        .i_den (r6_den_t),
        .o_quo (w_turn_quo),
        .o_ovf (w_turn_ovf)
    );

    logic signed [15:0] w_accel;
    t_side_b            w_last;

    always_comb begin
        w_last = r_sb[DIV_LAT-1];
        case (w_last.kind)
            ACC_FULL:  w_accel = CMD_MAX;
            ACC_BRAKE: w_accel = CMD_MIN;
            default:   w_accel = sat_cmd(w_last.neg_a, w_a_ovf, w_a_quo);
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r5_v      <= 1'b0;
            r6_v      <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                r_tv[i] <= 1'b0;
                r_bv[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r1_v      <= i_valid;
            r2_v      <= r1_v;
            r_tv[0]   <= r2_v;
            r3_v      <= r_tv[DIV_LAT-1];
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r6_v      <= r5_v;
            r_bv[0]   <= r6_v;
            r_o_valid <= r_bv[DIV_LAT-1];
            for (int i = 1; i < DIV_LAT; i++) begin
                r_tv[i] <= r_tv[i-1];
                r_bv[i] <= r_bv[i-1];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_e     <= $signed(16'(i_desired_heading - i_heading));
            r1_speed <= i_speed;
            r1_mode  <= i_mode;

            r2_side.e     <= r1_e;
            r2_side.speed <= r1_speed;
            r2_side.mode  <= r1_mode;
            r2_side.gt    <= (w2_a > {2'b00, r_turn_thr});
            r2_num        <= NUM_W'(w2_excess) << 15;
            r2_den        <= DEN_W'(w_span);

            r_ta[0] <= r2_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_ta[i] <= r_ta[i-1];
            end

            r3_side <= r_ta[DIV_LAT-1];
            r3_prod <= w3_t * w_omf;

            r4_side <= r3_side;
            r4_prod <= r_attack * w4_frac[15:0];

            r5_side <= r4_side;
            r5_err  <= $signed({1'b0, w5_target}) - $signed({1'b0, r4_side.speed});
            r5_band <= r4_side.speed * r_band_gain;

            r6_side  <= w6_side;
            r6_num_a <= NUM_W'(w6_err_mag) << 31;
            r6_den_a <= (r5_band < MIN_BAND) ? MIN_BAND : r5_band;
            r6_num_t <= NUM_W'(w6_e_mag) << 15;
            r6_den_t <= DEN_W'(w_sat);

            r_sb[0] <= r6_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sb[i] <= r_sb[i-1];
            end

            o_accel_cmd <= w_accel;
            o_turn_cmd  <= sat_cmd(w_last.neg_t, w_turn_ovf, w_turn_quo);
        end
    end

    a_brake_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_bv[DIV_LAT-1] && r_sb[DIV_LAT-1].kind == ACC_BRAKE
        |=> o_accel_cmd == CMD_MIN)
        else $error("brake result not at full negative command");

    a_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_bv[DIV_LAT-1] && r_sb[DIV_LAT-1].kind == ACC_FULL
        |=> o_accel_cmd == CMD_MAX)
        else $error("full throttle result not at full positive command");

    a_turn_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_bv[DIV_LAT-1] && !r_sb[DIV_LAT-1].neg_t |=> !o_turn_cmd[15])
        else $error("turn command sign flipped");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r6_v && !r1_v)
        else $error("pipeline valid after reset");

endmodule
